### rtl/b64ld_pkg.sv
// ----------------------------------------------------------------------------
// b64ld_pkg
// Shared types, constants and the character map of the base64 line decoder.
// ----------------------------------------------------------------------------
package b64ld_pkg;

    localparam int B64LD_QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_PAD = 8'h3D;

    localparam int         SEXTET_W  = 7;
    localparam int         HOLD_W    = 3 * SEXTET_W;
    localparam int         WORD_W    = 26;
    localparam logic [6:0] PAD_VALUE = 7'd99;

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
    } t_quartet;

    function automatic logic [SEXTET_W-1:0] map_char(input logic [7:0] c);
        logic [SEXTET_W-1:0] v;
        v = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = SEXTET_W'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = SEXTET_W'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = SEXTET_W'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            v = 7'd62;
        end else if (c == 8'h2F) begin
            v = 7'd63;
        end else if (c == CHAR_PAD) begin
            v = PAD_VALUE;
        end
        return v;
    endfunction

endpackage

### rtl/b64ld_front.sv
// ----------------------------------------------------------------------------
// b64ld_front
// Accepts characters, gathers quartets and hands each decoded quartet on.
// ----------------------------------------------------------------------------
module b64ld_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [7:0]          i_in_char,
    output logic                o_in_stall,
    input  logic                i_queue_full,
    output logic                o_push,
    output b64ld_pkg::t_quartet o_quartet
);
    import b64ld_pkg::*;

    logic [HOLD_W-1:0]   r_hold, n_hold;
    logic [1:0]          r_pos, n_pos;
    logic                r_third_pad, n_third_pad;
    logic                accept;
    logic                line_end;
    logic                is_pad;
    logic [SEXTET_W-1:0] value;
    logic [WORD_W-1:0]   word;
    logic [7:0]          byte_mid;
    logic [7:0]          byte_low;

    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign line_end   = (i_in_char == CHAR_NUL) || (i_in_char == CHAR_LF) ||
                        (i_in_char == CHAR_CR);
    assign is_pad     = (i_in_char == CHAR_PAD);
    assign value      = map_char(i_in_char);

    assign word = {1'b0, r_hold[3*SEXTET_W-1:2*SEXTET_W], 18'b0}
                + {7'b0, r_hold[2*SEXTET_W-1:SEXTET_W], 12'b0}
                + {13'b0, r_hold[SEXTET_W-1:0], 6'b0}
                + {19'b0, value};

    assign byte_mid = word[15:8];
    assign byte_low = word[7:0];

    always_comb begin
        o_quartet.bytes[0] = word[23:16];
        o_quartet.bytes[1] = r_third_pad ? byte_low : byte_mid;
        o_quartet.bytes[2] = byte_low;
        o_quartet.count    = 2'd1 + {1'b0, !r_third_pad} + {1'b0, !is_pad};
    end

    assign o_push = accept && !line_end && (r_pos == 2'd3);

    always_comb begin
        n_hold      = r_hold;
        n_pos       = r_pos;
        n_third_pad = r_third_pad;
        if (accept) begin
            if (line_end) begin
                n_hold      = '0;
                n_pos       = '0;
                n_third_pad = 1'b0;
            end else if (r_pos != 2'd3) begin
                if (r_pos == 2'd2) begin
                    n_third_pad = is_pad;
                end
                n_hold = {r_hold[2*SEXTET_W-1:0], value};
                n_pos  = r_pos + 2'd1;
            end else begin
                n_pos       = '0;
                n_third_pad = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold      <= '0;
            r_pos       <= '0;
            r_third_pad <= 1'b0;
        end else begin
            r_hold      <= n_hold;
            r_pos       <= n_pos;
            r_third_pad <= n_third_pad;
        end
    end

endmodule

### rtl/b64ld_queue.sv
// ----------------------------------------------------------------------------
// b64ld_queue
// Short first-in first-out queue of decoded quartets.
// ----------------------------------------------------------------------------
module b64ld_queue #(
    parameter int DEPTH = b64ld_pkg::B64LD_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b64ld_pkg::t_quartet i_quartet,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output b64ld_pkg::t_quartet o_head
);
    import b64ld_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_quartet         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_quartet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### rtl/b64ld_back.sv
// ----------------------------------------------------------------------------
// b64ld_back
// Unpacks each queued quartet into its bytes, one per cycle while the output
// is not stalled, into the output register.
// ----------------------------------------------------------------------------
module b64ld_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  b64ld_pkg::t_quartet i_q_head,
    output logic                o_pop,
    output logic                o_out_valid,
    output logic [7:0]          o_out_byte,
    output logic                o_quartet_last,
    input  logic                i_out_stall
);
    import b64ld_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic       load_ok;
    logic       is_last;

    assign load_ok = !r_valid || !i_out_stall;
    assign is_last = (r_idx == i_q_head.count - 2'd1);
    assign o_pop   = load_ok && i_q_valid && is_last;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        if (load_ok) begin
            n_valid = i_q_valid;
            if (i_q_valid) begin
                n_byte = i_q_head.bytes[r_idx];
                n_last = is_last;
                n_idx  = is_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_out_valid    = r_valid;
    assign o_out_byte     = r_byte;
    assign o_quartet_last = r_last;

endmodule

### rtl/base64_line_decoder.sv
// ----------------------------------------------------------------------------
// base64_line_decoder
// Streaming base64 decoder that takes one character per request and returns
// the decoded bytes of each quartet.
//
// The input channel carries one character per request on i_in_char. NUL, LF
// and CR end a line and drop any partial quartet. The output channel carries
// one decoded byte per request on o_out_byte, with o_quartet_last set on the
// final byte of a quartet.
// A character is taken every cycle while the quartet queue has room. The
// fourth character of a quartet enters the queue at its accepting edge; the
// first byte then passes through the output register. Bytes leave at one
// per cycle while the receiver does not stall, so a quartet of four characters
// yields its up to three bytes faster than the next quartet can arrive.
// When the receiver stalls, the output byte holds and the queue fills; once
// it is full, o_in_stall rises until a quartet has been drained.
// Reset empties the queue, clears o_out_valid and returns to the start of a
// quartet.
// ----------------------------------------------------------------------------
module base64_line_decoder #(
    parameter int QUEUE_DEPTH = b64ld_pkg::B64LD_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_in_char,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_quartet_last,
    input  logic       i_out_stall
);
    import b64ld_pkg::*;

    t_quartet front_quartet;
    t_quartet queue_head;
    logic     push;
    logic     queue_full;
    logic     queue_valid;
    logic     pop;

    b64ld_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_char    (i_in_char),
        .o_in_stall   (o_in_stall),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_quartet    (front_quartet)
    );

    b64ld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_quartet (front_quartet),
        .o_full    (queue_full),
        .i_pop     (pop),
        .o_valid   (queue_valid),
        .o_head    (queue_head)
    );

    b64ld_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (queue_valid),
        .i_q_head       (queue_head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_quartet_last (o_quartet_last),
        .i_out_stall    (i_out_stall)
    );

endmodule
